### hw/rtl/cbrf_pkg.sv
// ----------------------------------------------------------------------------
// cbrf_pkg: shared types and constants for the cubic bisection root finder
// Fixed-point format, multiplier digit split, register map, FSM states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cbrf_pkg;

    // Signed fixed point: VW bits total, FB fraction bits (Q16.32)
    localparam int VW     = 48;
    localparam int FB     = 32;
    localparam int TOL_W  = 32;
    localparam int ITER_W = 8;

    // Shared multiplier: one 16-bit digit of the multiplier operand per cycle
    localparam int MUL_DIGIT = 16;
    localparam int MUL_STEPS = (VW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int MUL_EXT_W = MUL_STEPS * MUL_DIGIT;
    localparam int PROD_W    = VW + MUL_EXT_W;
    localparam int PART_W    = VW + MUL_DIGIT + 1;
    localparam int QUOT_W    = PROD_W - FB;
    localparam int DIGIT_W   = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;

    // Horner rounds: multiply then add c2, c1, c0
    localparam int HORNER_ROUNDS = 3;
    localparam int ROUND_W       = 2;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = VW;

    // Stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = ((2 * VW + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VW + ITER_W + 7) / 8) * 8;

    typedef logic signed [VW-1:0] value_t;

    localparam value_t VALUE_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam value_t VALUE_MIN = {1'b1, {(VW-1){1'b0}}};

    // Reset values of the configuration registers
    localparam logic signed [63:0] FX_ONE = 64'sd1 <<< FB;
    localparam value_t COEFF_CUBIC_RST    = value_t'(FX_ONE);
    localparam value_t COEFF_SQUARE_RST   = value_t'(-64'sd2 * FX_ONE);
    localparam value_t COEFF_LINEAR_RST   = value_t'(-64'sd3 * FX_ONE);
    localparam value_t COEFF_CONSTANT_RST = value_t'(64'sd10 * FX_ONE);
    localparam logic [TOL_W-1:0] TOLERANCE_RST =
        TOL_W'(((64'd1 << FB) + 64'd9999999) / 64'd10000000);
    localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(100);

    // Register map
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_COEFF_CUBIC    = 3'd0,
        REG_COEFF_SQUARE   = 3'd1,
        REG_COEFF_LINEAR   = 3'd2,
        REG_COEFF_CONSTANT = 3'd3,
        REG_TOLERANCE      = 3'd4,
        REG_MAX_ITER       = 3'd5
    } cfg_reg_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL_INIT,
        ST_MUL,
        ST_ADD,
        ST_MID,
        ST_TEST,
        ST_UPDATE,
        ST_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic               load;
        logic               eval_init;
        logic               eval_lower;
        logic               mul_step;
        logic [DIGIT_W-1:0] digit;
        logic               add_step;
        logic [ROUND_W-1:0] round;
        logic               capture_fl;
        logic               mid;
        logic               update;
        logic               out_load;
        logic               out_converged;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic at_limit;
        logic below_tol;
        logic out_free;
    } dp_status_t;

endpackage

### hw/rtl/cubic_bisection_root_finder.sv
// Each request first evaluates p(lower); each halving then runs the midpoint,
// three Horner rounds of 3 multiplier digits plus 1 add, test, update.
// A run ends at the midpoint on the step limit, or at the test on convergence.
// One request is solved at a time on the shared 48x17 multiplier.
// Reset: synchronous active-low aresetn restores the register defaults, idles.
// ----------------------------------------------------------------------------
// cubic_bisection_root_finder: top level
// Bisection root search of a saturating Q16.32 cubic over a streamed interval.
// ----------------------------------------------------------------------------
module cubic_bisection_root_finder (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [cbrf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cbrf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // request stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cbrf_pkg::IN_TDATA_W-1:0]  s_tdata,   // lower_bound, upper_bound
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cbrf_pkg::OUT_TDATA_W-1:0] m_tdata,   // root, iterations_used
    output logic                             m_tuser    // converged
);
    import cbrf_pkg::*;

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic [VW-1:0]     out_root;
    logic [ITER_W-1:0] out_iters;

    cbrf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cbrf_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_lower      (s_tdata[VW-1:0]),
        .in_upper      (s_tdata[2*VW-1:VW]),
        .cmd           (cmd),
        .status        (status),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .out_root      (out_root),
        .out_iters     (out_iters),
        .out_converged (m_tuser)
    );

    // Result beat packing
    assign m_tdata = OUT_TDATA_W'({out_iters, out_root});

endmodule

### hw/rtl/cbrf_ctrl.sv
// ----------------------------------------------------------------------------
// cbrf_ctrl: bisection sequencer
// Walks each request through the lower-bound evaluation, then per step the
// midpoint, a Horner evaluation on the shared multiplier, the tolerance test
// and the interval update, until convergence or the step limit.
// ----------------------------------------------------------------------------
module cbrf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  cbrf_pkg::dp_status_t  status,
    output cbrf_pkg::dp_cmd_t     cmd
);
    import cbrf_pkg::*;

    localparam logic [DIGIT_W-1:0] LAST_DIGIT = DIGIT_W'(MUL_STEPS - 1);
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(HORNER_ROUNDS - 1);

    state_t             state_reg, state_next;
    logic [DIGIT_W-1:0] digit_reg, digit_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic               eval_lower_reg, eval_lower_next;
    logic               conv_reg, conv_next;

    // State and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            digit_reg      <= '0;
            round_reg      <= '0;
            eval_lower_reg <= 1'b0;
            conv_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            digit_reg      <= digit_next;
            round_reg      <= round_next;
            eval_lower_reg <= eval_lower_next;
            conv_reg       <= conv_next;
        end
    end

    // Next state
    always_comb begin
        state_next      = state_reg;
        digit_next      = digit_reg;
        round_next      = round_reg;
        eval_lower_next = eval_lower_reg;
        conv_next       = conv_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next      = ST_EVAL_INIT;
                    eval_lower_next = 1'b1;
                end
            end
            ST_EVAL_INIT: begin
                state_next = ST_MUL;
                digit_next = '0;
                round_next = '0;
            end
            ST_MUL: begin
                if (digit_reg == LAST_DIGIT) begin
                    state_next = ST_ADD;
                end else begin
                    digit_next = digit_reg + 1'b1;
                end
            end
            ST_ADD: begin
                digit_next = '0;
                if (round_reg == LAST_ROUND) begin
                    state_next = eval_lower_reg ? ST_MID : ST_TEST;
                end else begin
                    round_next = round_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MID: begin
                if (status.at_limit) begin
                    state_next = ST_OUT;
                    conv_next  = 1'b0;
                end else begin
                    state_next      = ST_EVAL_INIT;
                    eval_lower_next = 1'b0;
                end
            end
            ST_TEST: begin
                if (status.below_tol) begin
                    state_next = ST_OUT;
                    conv_next  = 1'b1;
                end else begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = ST_MID;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        s_tready          = (state_reg == ST_IDLE);
        cmd               = '0;
        cmd.digit         = digit_reg;
        cmd.round         = round_reg;
        cmd.eval_lower    = eval_lower_reg;
        cmd.out_converged = conv_reg;
        unique case (state_reg)
            ST_IDLE:      cmd.load      = s_tvalid;
            ST_EVAL_INIT: cmd.eval_init = 1'b1;
            ST_MUL:       cmd.mul_step  = 1'b1;
            ST_ADD: begin
                cmd.add_step   = 1'b1;
                cmd.capture_fl = eval_lower_reg && (round_reg == LAST_ROUND);
            end
            ST_MID:       cmd.mid      = 1'b1;
            ST_TEST:      cmd.mid      = 1'b0;
            ST_UPDATE:    cmd.update   = 1'b1;
            ST_OUT:       cmd.out_load = status.out_free;
            default:      cmd.load     = 1'b0;
        endcase
    end

endmodule

### hw/rtl/cbrf_datapath.sv
// ----------------------------------------------------------------------------
// cbrf_datapath: registers and arithmetic of the root finder
// Holds the coefficients, the working interval, the Horner accumulator, a
// digit-serial signed multiplier, saturation logic and the result register.
// ----------------------------------------------------------------------------
module cbrf_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [cbrf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cbrf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [cbrf_pkg::VW-1:0]        in_lower,
    input  logic [cbrf_pkg::VW-1:0]        in_upper,
    input  cbrf_pkg::dp_cmd_t              cmd,
    output cbrf_pkg::dp_status_t           status,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [cbrf_pkg::VW-1:0]        out_root,
    output logic [cbrf_pkg::ITER_W-1:0]    out_iters,
    output logic                           out_converged
);
    import cbrf_pkg::*;

    // Configuration registers
    value_t            coeff_cubic_reg, coeff_square_reg;
    value_t            coeff_linear_reg, coeff_constant_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [ITER_W-1:0] max_iter_reg;

    // Working registers
    value_t                   lower_reg, lower_next;
    value_t                   upper_reg, upper_next;
    value_t                   mid_reg, mid_next;
    value_t                   x_reg, x_next;
    value_t                   acc_reg, acc_next;
    value_t                   fl_reg, fl_next;
    logic [ITER_W-1:0]        step_reg, step_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    // Result stage
    value_t            root_reg;
    logic [ITER_W-1:0] iters_reg;
    logic              conv_reg;
    logic              out_valid_reg, out_valid_next;

    // Multiplier and saturation signals
    logic signed [MUL_EXT_W-1:0] x_ext;
    logic [DIGIT_W-1:0]          digit_pos;
    logic [MUL_DIGIT-1:0]        digit_bits;
    logic signed [MUL_DIGIT:0]   digit_op;
    logic signed [PART_W-1:0]    part;
    logic signed [PROD_W-1:0]    prod_calc;
    logic [QUOT_W-1:0]           quot;
    logic [QUOT_W-VW:0]          quot_top;
    value_t                      mul_sat;
    value_t                      coef_sel;
    logic [VW:0]                 sum_wide;
    value_t                      sum_sat;
    logic [VW:0]                 mid_sum;
    logic [VW-1:0]               acc_mag;
    logic                        keep_upper;

    // Configuration writes; indexes past the map are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_cubic_reg    <= COEFF_CUBIC_RST;
            coeff_square_reg   <= COEFF_SQUARE_RST;
            coeff_linear_reg   <= COEFF_LINEAR_RST;
            coeff_constant_reg <= COEFF_CONSTANT_RST;
            tol_reg            <= TOLERANCE_RST;
            max_iter_reg       <= MAX_ITER_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_COEFF_CUBIC:    coeff_cubic_reg    <= cfg_wdata;
                REG_COEFF_SQUARE:   coeff_square_reg   <= cfg_wdata;
                REG_COEFF_LINEAR:   coeff_linear_reg   <= cfg_wdata;
                REG_COEFF_CONSTANT: coeff_constant_reg <= cfg_wdata;
                REG_TOLERANCE:      tol_reg            <= cfg_wdata[TOL_W-1:0];
                REG_MAX_ITER:       max_iter_reg       <= cfg_wdata[ITER_W-1:0];
                default:            tol_reg            <= tol_reg;
            endcase
        end
    end

    // One multiplier digit per cycle, most significant first; the top digit
    // is signed, the rest unsigned
    always_comb begin
        x_ext      = MUL_EXT_W'(x_reg);
        digit_pos  = DIGIT_W'(MUL_STEPS - 1) - cmd.digit;
        digit_bits = x_ext[digit_pos*MUL_DIGIT +: MUL_DIGIT];
        digit_op   = {(cmd.digit == '0) & digit_bits[MUL_DIGIT-1], digit_bits};
        part       = acc_reg * digit_op;
        if (cmd.digit == '0) begin
            prod_calc = PROD_W'(part);
        end else begin
            prod_calc = $signed({prod_reg[PROD_W-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}})
                        + PROD_W'(part);
        end
    end

    // Product: floor shift by the fraction bits, then saturate
    always_comb begin
        quot     = prod_reg[PROD_W-1:FB];
        quot_top = quot[QUOT_W-1:VW-1];
        if (!quot_top[QUOT_W-VW] && (|quot_top)) begin
            mul_sat = VALUE_MAX;
        end else if (quot_top[QUOT_W-VW] && !(&quot_top)) begin
            mul_sat = VALUE_MIN;
        end else begin
            mul_sat = quot[VW-1:0];
        end
    end

    // Horner add with saturation
    always_comb begin
        case (cmd.round)
            2'd0:    coef_sel = coeff_square_reg;
            2'd1:    coef_sel = coeff_linear_reg;
            default: coef_sel = coeff_constant_reg;
        endcase
        sum_wide = {mul_sat[VW-1], mul_sat} + {coef_sel[VW-1], coef_sel};
        if (sum_wide[VW] != sum_wide[VW-1]) begin
            sum_sat = sum_wide[VW] ? VALUE_MIN : VALUE_MAX;
        end else begin
            sum_sat = sum_wide[VW-1:0];
        end
    end

    // Midpoint, tolerance test, sign test
    always_comb begin
        mid_sum    = {lower_reg[VW-1], lower_reg} + {upper_reg[VW-1], upper_reg};
        acc_mag    = acc_reg[VW-1] ? (~acc_reg + 1'b1) : acc_reg;
        keep_upper = (fl_reg != '0) && (acc_reg != '0)
                     && (fl_reg[VW-1] == acc_reg[VW-1]);
    end

    assign status.at_limit  = (step_reg == max_iter_reg);
    assign status.below_tol = (acc_mag < VW'(tol_reg));
    assign status.out_free  = !out_valid_reg || m_tready;

    // Working register updates
    always_comb begin
        lower_next = lower_reg;
        upper_next = upper_reg;
        mid_next   = mid_reg;
        x_next     = x_reg;
        acc_next   = acc_reg;
        fl_next    = fl_reg;
        step_next  = step_reg;
        prod_next  = prod_reg;
        if (cmd.load) begin
            lower_next = in_lower;
            upper_next = in_upper;
            step_next  = '0;
        end
        if (cmd.eval_init) begin
            x_next   = cmd.eval_lower ? lower_reg : mid_reg;
            acc_next = coeff_cubic_reg;
        end
        if (cmd.mul_step) begin
            prod_next = prod_calc;
        end
        if (cmd.add_step) begin
            acc_next = sum_sat;
        end
        if (cmd.capture_fl) begin
            fl_next = sum_sat;
        end
        if (cmd.mid) begin
            mid_next = mid_sum[VW:1];
        end
        // acc holds p(mid); when mid becomes the lower end its value is p(lower)
        if (cmd.update) begin
            if (keep_upper) begin
                lower_next = mid_reg;
                fl_next    = acc_reg;
            end else begin
                upper_next = mid_reg;
            end
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        lower_reg <= lower_next;
        upper_reg <= upper_next;
        mid_reg   <= mid_next;
        x_reg     <= x_next;
        acc_reg   <= acc_next;
        fl_reg    <= fl_next;
        step_reg  <= step_next;
        prod_reg  <= prod_next;
    end

    // Result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            root_reg  <= mid_reg;
            iters_reg <= step_reg;
            conv_reg  <= cmd.out_converged;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign out_root      = root_reg;
    assign out_iters     = iters_reg;
    assign out_converged = conv_reg;

endmodule

### hw/rtl/cbrf_checker.sv
// ----------------------------------------------------------------------------
// cbrf_checker: port-level checks for the root finder
// Result hold under backpressure, reset state, and request/result ordering.
// ----------------------------------------------------------------------------
module cbrf_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [cbrf_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tuser
);
    import cbrf_pkg::*;

    // A stalled result beat holds its contents
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

    // Once a request is taken the block is busy solving it
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while a solve was in flight");

    // A new result appears only at the end of a solve, which frees the input
    a_result_ends_solve: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready && !$past(s_tready))
        else $error("result appeared outside the end of a solve");

endmodule

bind cubic_bisection_root_finder cbrf_checker u_cbrf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### dv/cubic_bisection_root_finder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bisection_root_finder_test: self-checking bench for the root finder
// Streams intervals into the block and predicts every root, step count and
// converged flag with a local saturating Q16.32 bisection. The bench sweeps
// coefficient, tolerance and step-limit settings, and stalls both streams
// at random, including one long output hold-off.
// ----------------------------------------------------------------------------
module cubic_bisection_root_finder_test;

    import cbrf_pkg::*;

    localparam int IDLE_PCT        = 31;
    localparam int HOLD_CYCLES     = 1500;
    localparam int WATCHDOG_CYCLES = 30000;

    // Indexes past the register map; writes there must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        value_t            root;
        logic [ITER_W-1:0] steps;
        logic              converged;
    } root_result_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    // Shadow copy of the register file
    value_t            cubic_q    = COEFF_CUBIC_RST;
    value_t            square_q   = COEFF_SQUARE_RST;
    value_t            linear_q   = COEFF_LINEAR_RST;
    value_t            constant_q = COEFF_CONSTANT_RST;
    logic [TOL_W-1:0]  tol_q      = TOLERANCE_RST;
    logic [ITER_W-1:0] limit_q    = MAX_ITER_RST;

    root_result_t pending_roots[$];

    int mismatch_count = 0;
    int gap_pct        = IDLE_PCT;
    int stall_pct      = IDLE_PCT;
    int hold_orders    = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    cubic_bisection_root_finder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // lower_bound, upper_bound
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // root, iterations_used
        .m_tuser   (m_tuser)     // converged
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Bisection predictor
    // ------------------------------------------------------------------
    function automatic value_t clamp_value(wide_t v);
        if (v > wide_t'(VALUE_MAX)) return VALUE_MAX;
        if (v < wide_t'(VALUE_MIN)) return VALUE_MIN;
        return value_t'(v);
    endfunction

    // exact product, floor shift by the fraction bits, then saturate
    function automatic value_t sat_product(value_t a, value_t b);
        wide_t p;
        p = wide_t'(a) * wide_t'(b);
        return clamp_value(p >>> FB);
    endfunction

    function automatic value_t sat_sum(value_t a, value_t b);
        return clamp_value(wide_t'(a) + wide_t'(b));
    endfunction

    // Horner form: ((c3*x + c2)*x + c1)*x + c0
    function automatic value_t poly_value(value_t x);
        value_t acc;
        acc = sat_sum(sat_product(cubic_q, x), square_q);
        acc = sat_sum(sat_product(acc, x), linear_q);
        return sat_sum(sat_product(acc, x), constant_q);
    endfunction

    function automatic root_result_t bisect_interval(value_t lower, value_t upper);
        value_t            lo_end;
        value_t            hi_end;
        value_t            mid;
        value_t            f_mid;
        value_t            f_lo;
        wide_t             mag;
        logic [ITER_W-1:0] steps;
        root_result_t      res;
        bit                done;
        lo_end = lower;
        hi_end = upper;
        steps  = '0;
        done   = 1'b0;
        res    = '0;
        while (!done) begin
            mid = value_t'((wide_t'(lo_end) + wide_t'(hi_end)) >>> 1);
            // step limit wins over the tolerance test
            if (steps == limit_q) begin
                res.root      = mid;
                res.steps     = steps;
                res.converged = 1'b0;
                done          = 1'b1;
            end else begin
                f_mid = poly_value(mid);
                mag   = (f_mid < 0) ? -wide_t'(f_mid) : wide_t'(f_mid);
                if (mag < wide_t'(tol_q)) begin
                    res.root      = mid;
                    res.steps     = steps;
                    res.converged = 1'b1;
                    done          = 1'b1;
                end else begin
                    // upper half only on two nonzero values of equal sign
                    f_lo = poly_value(lo_end);
                    if (f_lo != 0 && f_mid != 0 && ((f_lo < 0) == (f_mid < 0)))
                        lo_end = mid;
                    else
                        hi_end = mid;
                    steps = steps + 1'b1;
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Value helpers
    // ------------------------------------------------------------------
    function automatic value_t fixed_from_int(int n);
        return value_t'(longint'(n) <<< FB);
    endfunction

    // signed random in roughly +/- 2^bits
    function automatic value_t rand_span(int bits);
        longint r;
        r = {$urandom, $urandom};
        return value_t'(r >>> (63 - bits));
    endfunction

    function automatic value_t rand_coeff();
        if ($urandom_range(0, 7) == 0)
            return value_t'({$urandom, $urandom});
        return rand_span(36);
    endfunction

    // ------------------------------------------------------------------
    // Mismatch report
    // ------------------------------------------------------------------
    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Register writes
    // ------------------------------------------------------------------
    task automatic put_reg(logic [CFG_ADDR_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // writes the whole map plus both spare indexes, junk in unused high bits
    task automatic set_regs(value_t c3, value_t c2, value_t c1, value_t c0,
                            logic [TOL_W-1:0] tol, logic [ITER_W-1:0] lim);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        put_reg(REG_COEFF_CUBIC, c3);
        put_reg(REG_COEFF_SQUARE, c2);
        put_reg(REG_COEFF_LINEAR, c1);
        put_reg(REG_COEFF_CONSTANT, c0);
        put_reg(REG_TOLERANCE, {junk[CFG_DATA_W-1:TOL_W], tol});
        put_reg(REG_MAX_ITER, {junk[CFG_DATA_W-1:ITER_W], lim});
        put_reg(REG_SPARE_LO, value_t'({$urandom, $urandom}));
        put_reg(REG_SPARE_HI, value_t'({$urandom, $urandom}));
        cfg_we     <= 1'b0;
        cubic_q    = c3;
        square_q   = c2;
        linear_q   = c1;
        constant_q = c0;
        tol_q      = tol;
        limit_q    = lim;
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic send_interval(value_t lower, value_t upper);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({upper, lower});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_roots.push_back(bisect_interval(lower, upper));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_roots.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side: check each beat, then pick the next ready value
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        root_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_roots.size() == 0) begin
                note_mismatch("result beat with nothing pending", m_tdata, '0);
            end else begin
                want = pending_roots.pop_front();
                if (m_tdata[VW-1:0] !== want.root)
                    note_mismatch("root", m_tdata[VW-1:0], want.root);
                if (m_tdata[VW+ITER_W-1:VW] !== want.steps)
                    note_mismatch("iterations_used", m_tdata[VW+ITER_W-1:VW], want.steps);
                if (m_tuser !== want.converged)
                    note_mismatch("converged", m_tuser, want.converged);
            end
        end
        // long hold-off when a test orders one
        if (hold_served != hold_orders) begin
            hold_left = HOLD_CYCLES;
            hold_served++;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: too long without any beat on either stream
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_CYCLES) begin
            $display("timeout: no beat for %0d cycles", WATCHDOG_CYCLES);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset coefficients: x^3 - 2x^2 - 3x + 10, root at -2
    task automatic test_reset_defaults();
        send_interval(fixed_from_int(-3), fixed_from_int(0));
        send_interval(fixed_from_int(-2), fixed_from_int(-2));
        send_interval(fixed_from_int(4), fixed_from_int(-3));
        wait_drained();
    endtask

    // limit of zero returns the first midpoint before the tolerance test
    task automatic test_zero_step_limit();
        set_regs(COEFF_CUBIC_RST, COEFF_SQUARE_RST, COEFF_LINEAR_RST,
                 COEFF_CONSTANT_RST, TOLERANCE_RST, '0);
        send_interval(VALUE_MIN, VALUE_MAX);
        send_interval(VALUE_MAX, VALUE_MIN);
        send_interval(VALUE_MAX, VALUE_MAX);
        send_interval(fixed_from_int(-2), fixed_from_int(-2));
        wait_drained();
    endtask

    // saturating coefficients and bounds at the widest step limit
    task automatic test_saturation_extremes();
        set_regs(VALUE_MAX, VALUE_MIN, VALUE_MAX, VALUE_MIN, '0, '1);
        send_interval(VALUE_MIN, VALUE_MAX);
        send_interval(fixed_from_int(-1), fixed_from_int(1));
        wait_drained();
        set_regs(VALUE_MIN, VALUE_MAX, VALUE_MIN, VALUE_MAX, '1, '1);
        send_interval(VALUE_MIN, VALUE_MAX);
        send_interval(VALUE_MAX, VALUE_MIN);
        wait_drained();
    endtask

    // zero at the lower end or at a midpoint, with zero tolerance
    task automatic test_zero_sign_cases();
        set_regs(COEFF_CUBIC_RST, COEFF_SQUARE_RST, COEFF_LINEAR_RST,
                 COEFF_CONSTANT_RST, '0, ITER_W'(20));
        send_interval(fixed_from_int(-2), fixed_from_int(5));
        send_interval(fixed_from_int(-4), fixed_from_int(0));
        send_interval(fixed_from_int(-2), fixed_from_int(-2));
        wait_drained();
    endtask

    // widest tolerance converges early
    task automatic test_loose_tolerance();
        set_regs(COEFF_CUBIC_RST, COEFF_SQUARE_RST, COEFF_LINEAR_RST,
                 COEFF_CONSTANT_RST, '1, '1);
        send_interval(fixed_from_int(-3), fixed_from_int(0));
        send_interval(fixed_from_int(-8), fixed_from_int(8));
        wait_drained();
    endtask

    // one random setting, then a batch of mostly ordered intervals
    task automatic run_random_phase(int count, int max_limit);
        logic [TOL_W-1:0] tol;
        value_t           a;
        value_t           b;
        case ($urandom_range(0, 9))
            0:       tol = '0;
            1:       tol = '1;
            2:       tol = $urandom;
            default: tol = TOL_W'($urandom_range(1, 1 << 20));
        endcase
        set_regs(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(), tol,
                 ITER_W'($urandom_range(0, max_limit)));
        repeat (count) begin
            a = rand_span(36);
            b = rand_span(36);
            case ($urandom_range(0, 9))
                0:       send_interval(value_t'({$urandom, $urandom}),
                                       value_t'({$urandom, $urandom}));
                1:       send_interval(a, b);
                2:       send_interval(a, a + value_t'($urandom_range(0, 1 << 16)));
                default: send_interval((a < b) ? a : b, (a < b) ? b : a);
            endcase
        end
        wait_drained();
    endtask

    task automatic test_random_sweep();
        repeat (8) run_random_phase(70, 48);
    endtask

    task automatic test_deep_search();
        run_random_phase(20, 255);
    endtask

    // no idling on either side
    task automatic test_calm_stretch();
        gap_pct   = 0;
        stall_pct = 0;
        run_random_phase(60, 24);
        gap_pct   = IDLE_PCT;
        stall_pct = IDLE_PCT;
    endtask

    // output held off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        gap_pct = 0;
        hold_orders++;
        run_random_phase(40, 8);
        gap_pct = IDLE_PCT;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_zero_step_limit();
        test_saturation_extremes();
        test_zero_sign_cases();
        test_loose_tolerance();
        test_random_sweep();
        test_backpressure();
        test_calm_stretch();
        test_deep_search();

        // room for any stray result at the current step limit
        repeat (16 * int'(limit_q) + 48) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
hw/rtl/cbrf_pkg.sv
hw/rtl/cbrf_ctrl.sv
hw/rtl/cbrf_datapath.sv
hw/rtl/cubic_bisection_root_finder.sv
hw/rtl/cbrf_checker.sv
dv/cubic_bisection_root_finder_test.sv
